/* rtl/core/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, screen defaults, cell constants and operation codes shared by
// the console writer, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Fixed field widths of the command and response transactions.
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  // Default screen geometry.
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;

  // A blank cell is a space in light grey on black.
  localparam logic [CELL_W-1:0]  BLANK_CELL       = 16'h0720;
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0A;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

  // Command operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_PUT_CURSOR = 2'd0,
    OP_PUT_AT     = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ       = 2'd3
  } op_t;

endpackage

/* rtl/core/tcw_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready interfaces for the command, response and color configuration
// channels of the console writer.
// ----------------------------------------------------------------------------

// Command channel: one transaction is one console operation.
interface tcw_cmd_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  op_t                operation;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] entry_color;
  logic [COL_W-1:0]   pos_col;
  logic [ROW_W-1:0]   pos_row;

  modport source (output valid, operation, char_code, entry_color, pos_col, pos_row,
                  input ready);
  modport sink   (input valid, operation, char_code, entry_color, pos_col, pos_row,
                  output ready);
endinterface

// Response channel: one transaction per accepted command.
interface tcw_rsp_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic              scrolled;
  logic              bad_position;

  modport source (output valid, cell_value, cursor_row, cursor_col, scrolled, bad_position,
                  input ready);
  modport sink   (input valid, cell_value, cursor_row, cursor_col, scrolled, bad_position,
                  output ready);
endinterface

// Configuration channel: writes the color used for characters at the cursor.
interface tcw_cfg_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] text_color;

  modport source (output valid, text_color, input ready);
  modport sink   (input valid, text_color, output ready);
endinterface

/* rtl/core/tcw_screen_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console screen RAM
// Single write port, single read port cell store with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram import tcw_pkg::*; #(
  parameter int DEPTH  = SCREEN_COLUMNS * SCREEN_ROWS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Character screen with cursor, scrolling, clear and cell read-back.
// ----------------------------------------------------------------------------
// The screen is a ROWS x COLUMNS store of 16-bit cells (color high byte, glyph
// low byte) held in one single-port-write, single-port-read RAM. Each command
// gives exactly one response. For a character at the cursor, a newline, a
// write at a position and a cell read, any RAM access is made in the cycle
// the command is accepted and the response is loaded in S_DONE once the
// response register is free. A command that scrolls walks the RAM copying
// each row up one cell per cycle in S_SCROLL, waits for the last copy write
// in S_DRAIN and then blanks the bottom row in S_FILL. A clear blanks one
// cell per cycle. After reset the same blanking pass runs before the first
// command is taken; color writes are taken at any time. One command is in
// work at a time, and the next command is taken while a response waits.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = SCREEN_COLUMNS,
  parameter int ROWS    = SCREEN_ROWS
) (
  input  logic     clk,
  input  logic     rst,
  tcw_cmd_if.sink  cmd,
  tcw_rsp_if.source rsp,
  tcw_cfg_if.sink  cfg
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ADDR_W-1:0] SCROLL_LAST   = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_FIRST  = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
  localparam logic [COL_W:0]    COL_END       = (COL_W + 1)'(COLUMNS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCROLL,
    S_DRAIN,
    S_FILL,
    S_DONE
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   sweep;
  logic                item_active;
  logic                copy_pend;
  logic [ADDR_W-1:0]   copy_addr;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [COLOR_W-1:0]  char_color;
  logic                res_use_rd;
  logic                res_scrolled;
  logic                res_bad;
  logic                rsp_valid;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CELL_W-1:0]   mem_rdata;

  logic [ADDR_W-1:0]   cur_addr;
  logic [ADDR_W-1:0]   pos_addr;
  logic                in_range;
  logic                is_newline;
  logic [COL_W:0]      col_inc;
  logic                wrap;
  logic                last_row;

  // Handshake outputs.
  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;

  // Cell addresses of the cursor and of the commanded position.
  assign cur_addr = ADDR_W'(int'(cur_row) * COLUMNS + int'(cur_col));
  assign pos_addr = ADDR_W'(int'(cmd.pos_row) * COLUMNS + int'(cmd.pos_col));
  assign in_range = (int'(cmd.pos_col) < COLUMNS) && (int'(cmd.pos_row) < ROWS);

  // Cursor advance: a newline or the end of a row moves to the next row.
  assign is_newline = (cmd.char_code == NEWLINE_CODE);
  assign col_inc    = {1'b0, cur_col} + 1'b1;
  assign wrap       = is_newline || (col_inc == COL_END);
  assign last_row   = (cur_row == LAST_ROW);

  // RAM port selection. Copy writes only occur while scrolling, so they never
  // collide with a command write or a blanking write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = pos_addr;
    if (copy_pend) begin
      mem_we    = 1'b1;
      mem_waddr = copy_addr;
      mem_wdata = mem_rdata;
    end
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.operation)
            OP_PUT_CURSOR: begin
              if (!is_newline) begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {char_color, cmd.char_code};
              end
            end
            OP_PUT_AT: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = pos_addr;
                mem_wdata = {cmd.entry_color, cmd.char_code};
              end
            end
            OP_READ: begin
              mem_re = in_range;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCROLL: begin
        mem_re    = 1'b1;
        mem_raddr = sweep + ROW_STRIDE;
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_screen_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Command sequencer, cursor, color register and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      sweep       <= '0;
      item_active <= 1'b0;
      copy_pend   <= 1'b0;
      cur_row     <= '0;
      cur_col     <= '0;
      char_color  <= TEXT_COLOR_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        char_color <= cfg.text_color;
      end
      // A taken response frees the register unless a new one loads now.
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      // Each scroll read is written back one row up in the next cycle.
      copy_pend <= (state == S_SCROLL);

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            item_active  <= 1'b1;
            res_use_rd   <= (cmd.operation == OP_READ) && in_range;
            res_scrolled <= (cmd.operation == OP_PUT_CURSOR) && wrap && last_row;
            res_bad      <= ((cmd.operation == OP_PUT_AT) || (cmd.operation == OP_READ)) &&
                            !in_range;
            unique case (cmd.operation)
              OP_PUT_CURSOR: begin
                if (wrap) begin
                  cur_col <= '0;
                  if (last_row) begin
                    sweep <= '0;
                    state <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                    state   <= S_DONE;
                  end
                end else begin
                  cur_col <= col_inc[COL_W-1:0];
                  state   <= S_DONE;
                end
              end
              OP_PUT_AT: begin
                state <= S_DONE;
              end
              OP_CLEAR: begin
                sweep <= '0;
                state <= S_FILL;
              end
              OP_READ: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        // Copy each cell one row up; the write lands in the cycle after its read.
        S_SCROLL: begin
          copy_addr <= sweep;
          if (sweep == SCROLL_LAST) begin
            state <= S_DRAIN;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        // The last copy write lands here, then the bottom row is blanked.
        S_DRAIN: begin
          sweep <= BOTTOM_FIRST;
          state <= S_FILL;
        end
        // Blank from sweep to the last cell.
        S_FILL: begin
          if (sweep == LAST_CELL) begin
            state <= item_active ? S_DONE : S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        // Hand the result over once the response register is free.
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid        <= 1'b1;
            rsp.cell_value   <= res_use_rd ? mem_rdata : '0;
            rsp.cursor_row   <= cur_row;
            rsp.cursor_col   <= cur_col;
            rsp.scrolled     <= res_scrolled;
            rsp.bad_position <= res_bad;
            item_active      <= 1'b0;
            state            <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/core/tcw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on the console writer, attached by a bind statement.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = SCREEN_COLUMNS,
  parameter int ROWS    = SCREEN_ROWS
) (
  input logic              clk,
  input logic              rst,
  input logic              cmd_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [CELL_W-1:0] cell_value,
  input logic [ROW_W-1:0]  cursor_row,
  input logic [COL_W-1:0]  cursor_col,
  input logic              scrolled,
  input logic              bad_position
);

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_value) &&
      $stable(cursor_row) && $stable(cursor_col) && $stable(scrolled) &&
      $stable(bad_position))
    else $error("response changed while stalled");

  // The reported cursor always lies on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(cursor_row) < ROWS) && (int'(cursor_col) < COLUMNS))
    else $error("cursor reported off the screen");

  // A scroll leaves the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && scrolled |-> (int'(cursor_row) == ROWS - 1) && (cursor_col == '0))
    else $error("scroll left the cursor off the bottom row start");

  // A rejected position returns no cell data and never scrolls.
  a_bad_position: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bad_position |-> (cell_value == '0) && !scrolled)
    else $error("bad position with cell data or scroll");

  // The screen is blanked after reset before any command is taken.
  a_init_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !cmd_ready)
    else $error("command taken before the screen was blanked");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .cell_value   (rsp.cell_value),
  .cursor_row   (rsp.cursor_row),
  .cursor_col   (rsp.cursor_col),
  .scrolled     (rsp.scrolled),
  .bad_position (rsp.bad_position)
);
